/* rtl/mefr_pkg.sv */
// Shared types and constants for the Manchester edge frame receiver.
// No dependencies; imported by all rtl modules and the port checker.
package mefr_pkg;

    localparam int FRAME_BITS = 34;
    localparam int TIME_WIDTH = 64;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = $clog2(FRAME_BITS + 1);
    localparam int CFG_IDX_W  = 2;

    localparam logic [31:0] BIT_TIMEOUT_RST   = 32'd800000;
    localparam logic [31:0] TRANS_TIMEOUT_RST = 32'd1300000;
    localparam logic [31:0] IDLE_GAP_RST      = 32'd100000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INVERT      = 2'd0,
        CFG_BIT_TIMEOUT = 2'd1,
        CFG_TRANS_TIMEOUT = 2'd2,
        CFG_IDLE_GAP    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_GAP      = 3'd1,
        EV_SAME     = 3'd2,
        EV_BIT_TO   = 3'd3,
        EV_MID_TO   = 3'd4
    } t_event;

    typedef struct packed {
        logic        invert;
        logic [31:0] bit_timeout;
        logic [31:0] trans_timeout;
        logic [31:0] idle_gap;
    } t_cfg;

    typedef struct packed {
        logic              frame_valid;
        logic [DATA_W-1:0] frame_data;
        t_event            event_code;
        logic [31:0]       error_total;
    } t_result;

endpackage

/* rtl/manchester_edge_frame_receiver.sv */
// Manchester (bi-phase-L) edge-driven frame receiver, top level.
// Depends on mefr_pkg, mefr_cfg_regs and mefr_core.
//
// Each input item is one line edge (level and timestamp). An item is
// registered on accept in the input register and processed from there
// once the output register is empty or being taken; its result lands in
// the output register and stays valid there until it is taken.
// One item is taken every cycle when the output is not stalled. The
// per-item step is a single 64-bit subtract, three interval compares and
// a shift, done combinationally between the input and result registers.
// Every edge yields exactly one result item. No clearing pass follows
// reset. Configuration writes are taken in any cycle and should be made
// only while no item is in flight.
module manchester_edge_frame_receiver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_line_level,
    input  logic [mefr_pkg::TIME_WIDTH-1:0] i_edge_time_ns,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_frame_valid,
    output logic [mefr_pkg::DATA_W-1:0]     o_frame_data,
    output logic [2:0]                      o_event_code,
    output logic [31:0]                     o_error_total,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mefr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);
    import mefr_pkg::*;

    t_cfg                  cfg;
    t_result               core_res;
    logic                  advance;

    logic                  r_in_valid;
    logic                  r_in_level;
    logic [TIME_WIDTH-1:0] r_in_time;
    logic                  r_out_valid;
    t_result               r_out;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    mefr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mefr_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_go         (advance),
        .i_line_level (r_in_level),
        .i_edge_time  (r_in_time),
        .o_result     (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_level <= i_line_level;
            r_in_time  <= i_edge_time_ns;
        end
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_frame_valid = r_out.frame_valid;
    assign o_frame_data  = r_out.frame_data;
    assign o_event_code  = r_out.event_code;
    assign o_error_total = r_out.error_total;

endmodule

/* rtl/mefr_cfg_regs.sv */
// Configuration register file for the Manchester edge frame receiver.
// Depends on mefr_pkg.
module mefr_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mefr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output mefr_pkg::t_cfg                o_cfg
);
    import mefr_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.invert        <= 1'b0;
            r_cfg.bit_timeout   <= BIT_TIMEOUT_RST;
            r_cfg.trans_timeout <= TRANS_TIMEOUT_RST;
            r_cfg.idle_gap      <= IDLE_GAP_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_INVERT:        r_cfg.invert        <= i_cfg_data[0];
                CFG_BIT_TIMEOUT:   r_cfg.bit_timeout   <= i_cfg_data;
                CFG_TRANS_TIMEOUT: r_cfg.trans_timeout <= i_cfg_data;
                CFG_IDLE_GAP:      r_cfg.idle_gap      <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/mefr_core.sv */
// Line state, shift register and error counter; computes one result per edge.
// Depends on mefr_pkg.
module mefr_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mefr_pkg::t_cfg                 i_cfg,
    input  logic                           i_go,
    input  logic                           i_line_level,
    input  logic [mefr_pkg::TIME_WIDTH-1:0] i_edge_time,
    output mefr_pkg::t_result              o_result
);
    import mefr_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BIT  = 2'd1,
        PH_MID  = 2'd2
    } t_phase;

    t_phase                r_phase,      n_phase;
    logic [FRAME_BITS-1:0] r_shift,      n_shift;
    logic [CNT_W-1:0]      r_cnt,        n_cnt;
    logic [TIME_WIDTH-1:0] r_prev_time;
    logic                  r_prev_level;
    logic [31:0]           r_err,        n_err;

    logic [TIME_WIDTH-1:0] dt;
    logic                  lt_bit, lt_trans, gt_gap;
    logic                  data_bit;
    t_event                ev;
    logic                  do_take, do_err;
    t_event                err_code;

    assign dt       = i_edge_time - r_prev_time;
    assign lt_bit   = dt < TIME_WIDTH'(i_cfg.bit_timeout);
    assign lt_trans = dt < TIME_WIDTH'(i_cfg.trans_timeout);
    assign gt_gap   = dt > TIME_WIDTH'(i_cfg.idle_gap);
    assign data_bit = i_cfg.invert ? i_line_level : ~i_line_level;

    always_comb begin
        n_phase  = r_phase;
        n_shift  = r_shift;
        n_cnt    = r_cnt;
        n_err    = r_err;
        ev       = EV_NONE;
        do_take  = 1'b0;
        do_err   = 1'b0;
        err_code = EV_NONE;

        if (gt_gap && r_phase != PH_IDLE) begin
            n_phase = PH_IDLE;
            n_shift = '0;
            n_cnt   = '0;
            ev      = EV_GAP;
        end

        case (n_phase)
            PH_BIT: begin
                if (lt_bit) begin
                    n_phase = PH_MID;
                    do_take = 1'b1;
                end else begin
                    do_err   = 1'b1;
                    err_code = EV_BIT_TO;
                end
            end
            PH_MID: begin
                if (lt_bit) begin
                    n_phase = PH_BIT;
                end else if (lt_trans) begin
                    do_take = 1'b1;
                end else begin
                    do_err   = 1'b1;
                    err_code = EV_MID_TO;
                end
            end
            default: ;
        endcase

        if (do_take) begin
            if (r_prev_level != i_line_level) begin
                n_shift = {n_shift[FRAME_BITS-2:0], data_bit};
                n_cnt   = CNT_W'(n_cnt + 1'b1);
                ev      = EV_NONE;
            end else begin
                do_err   = 1'b1;
                err_code = EV_SAME;
            end
        end

        if (do_err) begin
            n_err   = r_err + 32'd1;
            n_phase = PH_IDLE;
            n_shift = '0;
            n_cnt   = '0;
            ev      = err_code;
        end

        if (n_phase != PH_BIT && n_phase != PH_MID) begin
            n_phase = (i_line_level == ~i_cfg.invert) ? PH_BIT : PH_IDLE;
        end

        o_result.frame_valid = 1'b0;
        o_result.frame_data  = '0;
        if (n_cnt >= CNT_W'(FRAME_BITS)) begin
            o_result.frame_valid = 1'b1;
            o_result.frame_data  = DATA_W'(n_shift >> 1);
            n_phase = PH_IDLE;
            n_shift = '0;
            n_cnt   = '0;
        end
        o_result.event_code  = ev;
        o_result.error_total = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_shift      <= '0;
            r_cnt        <= '0;
            r_prev_time  <= '0;
            r_prev_level <= 1'b0;
            r_err        <= '0;
        end else if (i_go) begin
            r_phase      <= n_phase;
            r_shift      <= n_shift;
            r_cnt        <= n_cnt;
            r_prev_time  <= i_edge_time;
            r_prev_level <= i_line_level;
            r_err        <= n_err;
        end
    end

endmodule

/* rtl/mefr_port_checker.sv */
// Port-level checks for the Manchester edge frame receiver, with bind.
// Depends on mefr_pkg and manchester_edge_frame_receiver.
module mefr_port_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_frame_valid,
    input logic [mefr_pkg::DATA_W-1:0] o_frame_data,
    input logic [2:0]                  o_event_code,
    input logic [31:0]                 o_error_total
);
    import mefr_pkg::*;

    logic        out_acc;
    logic        is_err;
    logic        r_seen;
    logic [31:0] r_last_err;

    assign out_acc = o_valid && i_ready;
    assign is_err  = o_event_code == EV_SAME || o_event_code == EV_BIT_TO
                     || o_event_code == EV_MID_TO;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (out_acc) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_last_err <= o_error_total;
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_frame_data)
        && $stable(o_error_total))
        else $error("stalled result changed");

    a_no_frame_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_valid |-> o_frame_data == '0)
        else $error("data without a frame");

    a_frame_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_valid |-> o_event_code == EV_NONE)
        else $error("frame completed on an error edge");

    a_err_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_seen |->
        o_error_total == r_last_err + (is_err ? 32'd1 : 32'd0))
        else $error("error total does not track error events");

endmodule

bind manchester_edge_frame_receiver mefr_port_checker u_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_frame_valid (o_frame_valid),
    .o_frame_data  (o_frame_data),
    .o_event_code  (o_event_code),
    .o_error_total (o_error_total)
);
